// ----- rtl/b64sp_pkg.sv -----
// Package for the space-padded base64 encoder.
// Holds the word types of both channels, the symbol table function and constants.
// No dependencies.
package b64sp_pkg;

    localparam logic [7:0] SymPad   = 8'h20;
    localparam logic [7:0] SymPlus  = 8'h2b;
    localparam logic [7:0] SymSlash = 8'h2f;
    localparam int         GroupSyms = 4;
    localparam int         GroupCntW = $clog2(GroupSyms + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic       end_of_value;
    } out_word_t;

    // 6-bit index to base64 ASCII code
    function automatic logic [7:0] sextet_to_ascii(input logic [5:0] v);
        logic [7:0] w;
        logic [7:0] r;
        begin
            w = {2'b00, v};
            if (v < 6'd26)
            begin
                r = 8'h41 + w;
            end
            else if (v < 6'd52)
            begin
                r = 8'h61 + (w - 8'd26);
            end
            else if (v < 6'd62)
            begin
                r = 8'h30 + (w - 8'd52);
            end
            else if (v == 6'd62)
            begin
                r = SymPlus;
            end
            else
            begin
                r = SymSlash;
            end
            return r;
        end
    endfunction

endpackage

// ----- rtl/base64_space_pad_encoder.sv -----
// The first symbol of a group is offered the cycle after the byte that closes it.
// One symbol is offered per cycle while dst_ready is high; every group, space-padded if
// short, yields 4 symbols. Non-closing bytes are taken every cycle; a closing byte waits
// until the 4-symbol output buffer is empty or handing over its last symbol.
// Reset (rst_n low, async): no bytes pending, output buffer empty.
// Depends on b64sp_pkg.
module base64_space_pad_encoder
    import b64sp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_ready,
    input  in_word_t  src_word,
    output logic      dst_valid,
    input  logic      dst_ready,
    output out_word_t dst_word
);

    logic [15:0]          pend_bytes_reg;
    logic [15:0]          pend_bytes_next;
    logic [1:0]           pend_cnt_reg;
    logic [1:0]           pend_cnt_next;
    logic [7:0]           sym_reg  [GroupSyms];
    logic [7:0]           sym_next [GroupSyms];
    logic                 eov_reg;
    logic                 eov_next;
    logic [GroupCntW-1:0] out_cnt_reg;
    logic [GroupCntW-1:0] out_cnt_next;

    logic       take;
    logic       pop;
    logic       closes;
    logic       out_free;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] grp_sym [GroupSyms];

    assign dst_valid = (out_cnt_reg != '0);
    assign pop       = dst_valid && dst_ready;
    assign out_free  = (out_cnt_reg == '0) || ((out_cnt_reg == GroupCntW'(1)) && dst_ready);
    // a count of two or more means the incoming byte completes the group
    assign closes    = src_word.last_byte || pend_cnt_reg[1];
    assign src_ready = !closes || out_free;
    assign take      = src_valid && src_ready;

    assign dst_word.symbol       = sym_reg[0];
    assign dst_word.end_of_value = eov_reg && (out_cnt_reg == GroupCntW'(1));

    // group assembly; missing bytes read as zero
    always_comb
    begin
        unique case (pend_cnt_reg)
            2'd0:
            begin
                b0 = src_word.data_byte;
                b1 = 8'h00;
                b2 = 8'h00;
            end
            2'd1:
            begin
                b0 = pend_bytes_reg[7:0];
                b1 = src_word.data_byte;
                b2 = 8'h00;
            end
            default:
            begin
                b0 = pend_bytes_reg[15:8];
                b1 = pend_bytes_reg[7:0];
                b2 = src_word.data_byte;
            end
        endcase

        grp_sym[0] = sextet_to_ascii(b0[7:2]);
        grp_sym[1] = sextet_to_ascii({b0[1:0], b1[7:4]});
        grp_sym[2] = (pend_cnt_reg != 2'd0) ? sextet_to_ascii({b1[3:0], b2[7:6]}) : SymPad;
        grp_sym[3] = (pend_cnt_reg == 2'd2 || pend_cnt_reg == 2'd3)
                     ? sextet_to_ascii(b2[5:0]) : SymPad;
    end

    always_comb
    begin
        pend_bytes_next = pend_bytes_reg;
        pend_cnt_next   = pend_cnt_reg;
        eov_next        = eov_reg;
        out_cnt_next    = out_cnt_reg;
        for (int i = 0; i < GroupSyms; i++)
        begin
            sym_next[i] = sym_reg[i];
        end

        if (pop)
        begin
            out_cnt_next = out_cnt_reg - GroupCntW'(1);
            for (int i = 0; i < GroupSyms - 1; i++)
            begin
                sym_next[i] = sym_reg[i + 1];
            end
        end

        if (take)
        begin
            if (closes)
            begin
                pend_bytes_next = '0;
                pend_cnt_next   = 2'd0;
                eov_next        = src_word.last_byte;
                out_cnt_next    = GroupCntW'(GroupSyms);
                for (int i = 0; i < GroupSyms; i++)
                begin
                    sym_next[i] = grp_sym[i];
                end
            end
            else
            begin
                pend_bytes_next = {pend_bytes_reg[7:0], src_word.data_byte};
                pend_cnt_next   = pend_cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_bytes_reg <= '0;
            pend_cnt_reg   <= 2'd0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            pend_bytes_reg <= pend_bytes_next;
            pend_cnt_reg   <= pend_cnt_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        eov_reg <= eov_next;
        for (int i = 0; i < GroupSyms; i++)
        begin
            sym_reg[i] <= sym_next[i];
        end
    end

endmodule
